// File: design/sbl_pkg.sv
// Package for the superbee slope limiter: widths, item class codes, queue item struct.
// No dependencies.
`timescale 1ns / 1ps
package sbl_pkg;
  localparam int VAL_W    = 32;  // input sample width
  localparam int DIFF_W   = 33;  // backward / forward difference width
  localparam int W_W      = 18;  // weight register width, Q1.16
  localparam int W_FRAC   = 16;
  localparam int FAC_W    = 19;  // 1 +/- w
  localparam int PROD_W   = 52;  // DIFF_W + FAC_W
  localparam int ACC_W    = 53;
  localparam int SLOPE_W  = 33;
  localparam int LIM_FRAC = 16;
  localparam int LIM_W    = 18;
  localparam int QUO_W    = LIM_FRAC + 1;  // quotient bits, numerator <= denominator
  localparam int MAG_W    = 33;  // numerator / denominator width
  localparam int REM_W    = 33;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_ONE,
    CLS_DIV
  } sbl_cls_t;

  typedef struct packed {
    sbl_cls_t                   cls;
    logic [MAG_W-1:0]           num;
    logic [MAG_W-1:0]           den;
    logic signed [PROD_W-1:0]   prod_b;
    logic signed [PROD_W-1:0]   prod_f;
  } sbl_item_t;
endpackage

// File: design/sbl_in_if.sv
// Input channel interface: valid/ready plus the three cell values.
// Uses no package.
`timescale 1ns / 1ps
interface sbl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prev_value;
  logic signed [31:0] centre_value;
  logic signed [31:0] next_value;

  modport source (output valid, prev_value, centre_value, next_value, input ready);
  modport sink   (input valid, prev_value, centre_value, next_value, output ready);
endinterface

// File: design/sbl_out_if.sv
// Result channel interface: valid/ready plus slope and limiter.
// Uses no package.
`timescale 1ns / 1ps
interface sbl_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] slope;
  logic        [17:0] limiter;

  modport source (output valid, slope, limiter, input ready);
  modport sink   (input valid, slope, limiter, output ready);
endinterface

// File: design/sbl_front.sv
// Front end: takes items, forms differences, classifies the ratio, multiplies by weights.
// Depends on sbl_pkg.
`timescale 1ns / 1ps
module sbl_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              in_prev,
  input  logic signed [31:0]              in_centre,
  input  logic signed [31:0]              in_next,
  input  logic                            cfg_we,
  input  logic signed [17:0]              cfg_wdata,
  output logic                            push,
  output sbl_pkg::sbl_item_t              push_item,
  input  logic                            q_full
);
  import sbl_pkg::*;

  localparam int W_ONE = 1 << W_FRAC;

  logic signed [FAC_W-1:0]  w_plus_r, w_minus_r;
  logic                     s1_vld_r, s2_vld_r;
  logic signed [DIFF_W-1:0] db_r, df_r;
  sbl_item_t                item_r, item_nxt;
  logic                     adv;
  logic [MAG_W-1:0]         mag_a, mag_b, two_a, two_b;

  assign adv       = ~s2_vld_r | ~q_full;
  assign in_ready  = adv;
  assign push      = s2_vld_r & ~q_full;
  assign push_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_plus_r  <= FAC_W'(W_ONE);
      w_minus_r <= FAC_W'(W_ONE);
    end else if (cfg_we) begin
      w_plus_r  <= FAC_W'(W_ONE) + FAC_W'(cfg_wdata);
      w_minus_r <= FAC_W'(W_ONE) - FAC_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      db_r   <= DIFF_W'(in_centre) - DIFF_W'(in_prev);
      df_r   <= DIFF_W'(in_next) - DIFF_W'(in_centre);
      item_r <= item_nxt;
    end
  end

  always_comb begin
    mag_a = db_r[DIFF_W-1] ? MAG_W'(-db_r) : MAG_W'(db_r);
    mag_b = df_r[DIFF_W-1] ? MAG_W'(-df_r) : MAG_W'(df_r);
    two_a = {mag_a[MAG_W-2:0], 1'b0};
    two_b = {mag_b[MAG_W-2:0], 1'b0};
    item_nxt.prod_b = PROD_W'(db_r) * PROD_W'(w_plus_r);
    item_nxt.prod_f = PROD_W'(df_r) * PROD_W'(w_minus_r);
    item_nxt.cls = CLS_ZERO;
    item_nxt.num = two_a;
    item_nxt.den = mag_b;
    // opposite signs or a zero difference: r <= 0 or undefined, limiter 0
    priority if (db_r == '0 || df_r == '0 || db_r[DIFF_W-1] != df_r[DIFF_W-1]) begin
      item_nxt.cls = CLS_ZERO;
    end else if (two_a <= mag_b) begin
      item_nxt.cls = CLS_DIV;            // 2r
    end else if (mag_a <= mag_b) begin
      item_nxt.cls = CLS_ONE;
    end else begin
      item_nxt.cls = CLS_DIV;            // 2/(1+r) = 2b/(a+b)
      item_nxt.num = two_b;
      item_nxt.den = mag_a + mag_b;
    end
  end
endmodule

// File: design/sbl_fifo.sv
// Short queue of classified items between front and back.
// Depends on sbl_pkg.
`timescale 1ns / 1ps
module sbl_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sbl_pkg::sbl_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output sbl_pkg::sbl_item_t head
);
  import sbl_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  sbl_item_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow:  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
  a_cnt_range:    assert property (@(posedge clk) disable iff (!rst_n)
                                   cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count out of range");
endmodule

// File: design/sbl_back.sv
// Back end: slope rounding/saturation and a one-bit-per-stage divider pipeline.
// Depends on sbl_pkg.
`timescale 1ns / 1ps
module sbl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  output logic                pop,
  input  sbl_pkg::sbl_item_t  head,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [32:0]  out_slope,
  output logic        [17:0]  out_limiter
);
  import sbl_pkg::*;

  localparam int SH = W_FRAC + 1;
  localparam int SH_W = ACC_W - SH;

  logic                     vld_r   [QUO_W];
  sbl_cls_t                 cls_r   [QUO_W];
  logic [REM_W-1:0]         rem_r   [QUO_W];
  logic [MAG_W-1:0]         den_r   [QUO_W];
  logic [QUO_W-1:0]         quo_r   [QUO_W];
  logic signed [SLOPE_W-1:0] slope_r [QUO_W];

  logic                     out_vld_r;
  logic signed [SLOPE_W-1:0] out_slope_r;
  logic [LIM_W-1:0]         out_lim_r, lim_nxt;

  logic                     adv;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   sh;
  logic signed [SLOPE_W-1:0] slope_nxt;

  assign adv         = ~out_vld_r | out_ready;
  assign pop         = adv & ~empty;
  assign out_valid   = out_vld_r;
  assign out_slope   = out_slope_r;
  assign out_limiter = out_lim_r;

  // floor(acc / 2^17), clamped to the 33-bit signed range
  always_comb begin
    acc = ACC_W'(head.prod_b) + ACC_W'(head.prod_f);
    sh  = acc[ACC_W-1:SH];
    if (sh[SH_W-1:SLOPE_W-1] == '0 || sh[SH_W-1:SLOPE_W-1] == '1) begin
      slope_nxt = sh[SLOPE_W-1:0];
    end else if (sh[SH_W-1]) begin
      slope_nxt = {1'b1, {(SLOPE_W-1){1'b0}}};
    end else begin
      slope_nxt = {1'b0, {(SLOPE_W-1){1'b1}}};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [REM_W:0]   rin;
    logic [REM_W+1:0] dif;
    logic [MAG_W-1:0] den_in;
    logic [QUO_W-1:0] q_in;
    logic             bit_q;

    if (k == 0) begin : g_first
      assign rin    = {1'b0, head.num};
      assign den_in = head.den;
      assign q_in   = '0;
    end else begin : g_next
      assign rin    = {rem_r[k-1], 1'b0};
      assign den_in = den_r[k-1];
      assign q_in   = quo_r[k-1];
    end

    assign dif   = {1'b0, rin} - (REM_W+2)'(den_in);
    assign bit_q = ~dif[REM_W+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= (k == 0) ? ~empty : vld_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= bit_q ? dif[REM_W-1:0] : rin[REM_W-1:0];
        den_r[k] <= den_in;
        quo_r[k] <= {q_in[QUO_W-2:0], bit_q};
        if (k == 0) begin
          cls_r[k]   <= head.cls;
          slope_r[k] <= slope_nxt;
        end else begin
          cls_r[k]   <= cls_r[(k == 0) ? 0 : k-1];
          slope_r[k] <= slope_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  always_comb begin
    unique case (cls_r[QUO_W-1])
      CLS_ONE: lim_nxt = LIM_W'(1) << LIM_FRAC;
      CLS_DIV: lim_nxt = LIM_W'(quo_r[QUO_W-1]);
      default: lim_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_slope_r <= slope_r[QUO_W-1];
      out_lim_r   <= lim_nxt;
    end
  end

  a_lim_range: assert property (@(posedge clk) disable iff (!rst_n)
                                out_vld_r |-> out_lim_r <= (LIM_W'(2) << LIM_FRAC))
    else $error("limiter above 2");
  a_zero_cls: assert property (@(posedge clk) disable iff (!rst_n)
                               (adv && vld_r[QUO_W-1] && cls_r[QUO_W-1] == CLS_ZERO)
                               |=> out_lim_r == '0)
    else $error("zero class gave nonzero limiter");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
                                 (out_vld_r && !out_ready) |=> $stable(vld_r[QUO_W-1]))
    else $error("pipeline moved during stall");
endmodule

// File: design/superbee_slope_limiter_top.sv
// Top level of the superbee slope limiter: front end, queue, back end.
// Depends on sbl_pkg, sbl_in_if, sbl_out_if, sbl_front, sbl_fifo, sbl_back.
`timescale 1ns / 1ps
// Usage:
//  in_ch  : one item per valid/ready handshake, carrying prev, centre and next
//           cell values (signed Q16.16).
//  out_ch : one result per item, in order: weighted slope (signed Q17.16,
//           floor-rounded, saturated) and superbee limiter (unsigned Q2.16).
//  cfg_we/cfg_wdata : writes the slope weight (signed Q1.16); write only while
//           no items are in flight. Reset value 0.
//  Throughput: one item per cycle while out_ch does not stall. The limiter
//  division is a 17-stage restoring divider, one quotient bit per stage, so
//  it never iterates. Path: the accepting edge loads the first front stage;
//  the item then passes the second front stage, the queue write, the 17
//  divider stages and the output register before out_ch.valid rises.
//  Reset (rst_n low, synchronous) empties all stages and the queue.
//  When out_ch stalls, the back end holds; the four-entry queue keeps the
//  front end taking items until it fills, then in_ch.ready drops.
module superbee_slope_limiter_top (
  input  logic          clk,
  input  logic          rst_n,
  sbl_in_if.sink        in_ch,
  sbl_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic [17:0]   cfg_wdata
);
  import sbl_pkg::*;

  logic      push, pop, q_full, q_empty;
  sbl_item_t push_item, head;

  sbl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_prev   (in_ch.prev_value),
    .in_centre (in_ch.centre_value),
    .in_next   (in_ch.next_value),
    .cfg_we    (cfg_we),
    .cfg_wdata ($signed(cfg_wdata)),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  sbl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  sbl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (q_empty),
    .pop         (pop),
    .head        (head),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_slope   (out_ch.slope),
    .out_limiter (out_ch.limiter)
  );
endmodule
